/* design/ptss_pkg.sv */
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared types, codes and sizes for the periodic task slot scheduler.
// ----------------------------------------------------------------------------
package ptss_pkg;

  localparam int SLOT_COUNT   = 8;
  localparam int RESULT_LIMIT = 8;
  localparam int IDX_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RUN_W        = $clog2(RESULT_LIMIT + 1);

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_ADD      = 3'd1;
  localparam logic [2:0] CMD_DELETE   = 3'd2;
  localparam logic [2:0] CMD_CHANGE   = 3'd3;
  localparam logic [2:0] CMD_DISPATCH = 3'd4;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DELETED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_CHANGED  = 3'd4;
  localparam logic [2:0] ST_RUN      = 3'd5;
  localparam logic [2:0] ST_IDLE     = 3'd6;
  localparam logic [2:0] ST_TICKED   = 3'd7;

  typedef struct packed {
    logic [15:0] handle;
    logic [16:0] countdown;
    logic [15:0] period;
  } slot_t;

  // low three bits of a slot index for the result word
  function automatic logic [2:0] slot_code(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[2:0];
  endfunction

endpackage

/* design/periodic_task_slot_scheduler.sv */
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler
// Task slot table held in a ring of cells; each command rotates the ring once
// past a shared head unit that updates the slot entry and emits results.
// ----------------------------------------------------------------------------
// steps: register the command, turn the ring once, load the last result word
// a new command is taken only when idle, once the last result word has loaded
// a run word waiting to load behind a stalled output holds the ring
// reset: rst clears all slots, current slot and the control state
module periodic_task_slot_scheduler
  import ptss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [2:0]  cmd,
  input  logic [15:0] handle,
  input  logic [15:0] first_delay,
  input  logic [15:0] period,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  status,
  output logic [2:0]  slot,
  output logic [15:0] task_handle,
  output logic        last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state;
  logic [2:0]       cmd_r;
  logic [15:0]      handle_r;
  logic [15:0]      delay_r;
  logic [15:0]      period_r;
  logic [IDX_W-1:0] step;
  logic [IDX_W-1:0] current_slot;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_idx;
  logic [15:0]      pend_handle;
  logic [RUN_W-1:0] runs;

  slot_t cell_q [SLOT_COUNT];
  slot_t head;
  slot_t head_next;
  slot_t fill;
  logic  shift;
  logic  can_emit;
  logic  hit;
  logic  due;
  logic  emit_need;
  logic  load;
  logic [2:0]  load_status;
  logic [2:0]  load_slot;
  logic [15:0] load_handle;
  logic        load_last;

  // slot ring
  genvar gi;
  generate
    for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
      slot_t din;
      if (gi == SLOT_COUNT - 1) begin : g_tail
        assign din = head_next;
      end else begin : g_mid
        assign din = cell_q[gi+1];
      end
      ptss_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .din  (din),
        .dout (cell_q[gi])
      );
    end
  endgenerate

  assign head      = cell_q[0];
  assign can_emit  = !res_valid || !res_stall;
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    fill.handle    = handle_r;
    fill.countdown = {1'b0, delay_r} + 17'd1;
    fill.period    = period_r;
  end

  // head unit: what this command does to the slot at the head of the ring
  always_comb begin
    head_next = head;
    hit       = 1'b0;
    due       = 1'b0;
    case (cmd_r)
      CMD_TICK: begin
        if (head.countdown != '0) head_next.countdown = head.countdown - 17'd1;
      end
      CMD_ADD: begin
        hit = !found && (head.handle == '0) && (period_r != '0);
        if (hit) head_next = fill;
      end
      CMD_DELETE: begin
        hit = !found && (handle_r != '0) && (head.handle == handle_r);
        if (hit) head_next.handle = '0;
      end
      CMD_CHANGE: begin
        hit = (step == current_slot) && (period_r != '0);
        if (hit) head_next = fill;
      end
      CMD_DISPATCH: begin
        due = (head.handle != '0) && (head.countdown == '0) &&
              (runs < RUN_W'(RESULT_LIMIT));
        if (due) head_next.countdown = {1'b0, head.period};
      end
      default: begin
      end
    endcase
  end

  // a new due slot pushes the held run word out, not last
  assign emit_need = due && pend_valid;
  assign shift     = (state == S_SCAN) && (!emit_need || can_emit);

  always_comb begin
    load        = 1'b0;
    load_status = ST_RUN;
    load_slot   = slot_code(pend_idx);
    load_handle = pend_handle;
    load_last   = 1'b0;
    if (state == S_SCAN && emit_need && can_emit) begin
      load = 1'b1;
    end else if (state == S_DONE && can_emit) begin
      load        = 1'b1;
      load_last   = 1'b1;
      load_handle = '0;
      load_slot   = '0;
      case (cmd_r)
        CMD_TICK: load_status = ST_TICKED;
        CMD_ADD: begin
          load_status = found ? ST_ADDED : ST_FULL;
          if (found) load_slot = slot_code(found_idx);
        end
        CMD_DELETE: begin
          load_status = found ? ST_DELETED : ST_NOTFOUND;
          if (found) load_slot = slot_code(found_idx);
        end
        CMD_CHANGE: begin
          load_status = found ? ST_CHANGED : ST_NOTFOUND;
          if (found) load_slot = slot_code(current_slot);
        end
        default: begin
          if (pend_valid) begin
            load_status = ST_RUN;
            load_slot   = slot_code(pend_idx);
            load_handle = pend_handle;
          end else begin
            load_status = ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      current_slot <= '0;
      found        <= 1'b0;
      pend_valid   <= 1'b0;
      runs         <= '0;
      cmd_r        <= CMD_TICK;
      res_valid    <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd <= CMD_DISPATCH) begin
            state      <= S_SCAN;
            cmd_r      <= cmd;
            step       <= '0;
            found      <= 1'b0;
            pend_valid <= 1'b0;
            runs       <= '0;
          end
        end
        S_SCAN: begin
          if (shift) begin
            if (hit) begin
              found     <= 1'b1;
              found_idx <= step;
            end
            if (due) begin
              current_slot <= step;
              pend_valid   <= 1'b1;
              pend_idx     <= step;
              pend_handle  <= head.handle;
              runs         <= runs + RUN_W'(1);
            end
            if (step == IDX_W'(SLOT_COUNT - 1)) begin
              state <= S_DONE;
            end else begin
              step <= step + IDX_W'(1);
            end
          end
        end
        S_DONE: begin
          if (can_emit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      handle_r <= handle;
      delay_r  <= first_delay;
      period_r <= period;
    end
    if (load) begin
      status      <= load_status;
      slot        <= load_slot;
      task_handle <= load_handle;
      last        <= load_last;
    end
  end

`ifndef SYNTHESIS
  a_pend_only_dispatch: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> cmd_r == CMD_DISPATCH)
    else $error("run word held outside a dispatch");

  a_scan_cmd_known: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> cmd_r <= CMD_DISPATCH)
    else $error("ring turning for an unused command code");

  a_runs_limit: assert property (@(posedge clk) disable iff (rst)
    runs <= RUN_W'(RESULT_LIMIT))
    else $error("more runs than result limit");

  a_done_one_cycle_min: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && can_emit |=> state == S_IDLE && res_valid && last)
    else $error("final word not presented when leaving done");
`endif

endmodule

/* design/ptss_cell.sv */
// ----------------------------------------------------------------------------
// ptss_cell
// One slot of the rotating slot ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module ptss_cell
  import ptss_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  slot_t din,
  output slot_t dout
);

  slot_t entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (shift) begin
      entry <= din;
    end
  end

  assign dout = entry;

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives scheduler commands through the valid/stall input channel and checks
// every result word against a cycle-free model of the slot table kept here.
// Directed commands cover the corner cases, then a long random mix follows,
// with random idling on both sides, a long output hold-off and two drain pauses.
// ----------------------------------------------------------------------------
module testbench;
  import ptss_pkg::*;

  localparam int RANDOM_CMDS    = 344;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int IDLE_PERCENT   = 19;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] handle;
    logic [15:0] first_delay;
    logic [15:0] period;
    bit          wait_drain;
  } sched_cmd_t;

  typedef struct {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [15:0] task_handle;
    logic        last;
  } sched_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic [2:0]  cmd = CMD_TICK;
  logic [15:0] handle = 16'd0;
  logic [15:0] first_delay = 16'd0;
  logic [15:0] period = 16'd0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [2:0]  status;
  logic [2:0]  slot;
  logic [15:0] task_handle;
  logic        last;

  periodic_task_slot_scheduler dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .handle      (handle),
    .first_delay (first_delay),
    .period      (period),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status),
    .slot        (slot),
    .task_handle (task_handle),
    .last        (last)
  );

  always #4 clk = ~clk;

  // model of the slot table
  logic [15:0]      tbl_handle [SLOT_COUNT];
  logic [16:0]      tbl_count  [SLOT_COUNT];
  logic [15:0]      tbl_period [SLOT_COUNT];
  logic [IDX_W-1:0] cur_slot;

  sched_cmd_t  pending_cmds[$];
  sched_word_t due_words[$];
  sched_cmd_t  on_wire;
  int          cmds_taken = 0;
  int          total_cmds = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  // no idling on either side through this stretch
  wire calm = (cmds_taken >= 140) && (cmds_taken < 230);

  function automatic sched_word_t make_word(input logic [2:0] st, input logic [2:0] sl,
                                            input logic [15:0] th);
    sched_word_t w;
    w.status = st;
    w.slot = sl;
    w.task_handle = th;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic void load_slot(input int s, input sched_cmd_t c);
    tbl_handle[s] = c.handle;
    tbl_count[s] = 17'(c.first_delay) + 17'd1;
    tbl_period[s] = c.period;
  endfunction

  function automatic void predict_results(input sched_cmd_t c);
    sched_word_t words[$];
    int s;
    case (c.cmd)
      CMD_TICK: begin
        for (s = 0; s < SLOT_COUNT; s++)
          if (tbl_count[s] != 17'd0) tbl_count[s] = tbl_count[s] - 17'd1;
        words.push_back(make_word(ST_TICKED, 3'd0, 16'd0));
      end
      CMD_ADD: begin
        s = 0;
        while (s < SLOT_COUNT && tbl_handle[s] != 16'd0) s++;
        if (s < SLOT_COUNT && c.period != 16'd0) begin
          load_slot(s, c);
          words.push_back(make_word(ST_ADDED, 3'(s), 16'd0));
        end else begin
          words.push_back(make_word(ST_FULL, 3'd0, 16'd0));
        end
      end
      CMD_DELETE: begin
        s = SLOT_COUNT;
        if (c.handle != 16'd0) begin
          s = 0;
          while (s < SLOT_COUNT && tbl_handle[s] != c.handle) s++;
        end
        if (s < SLOT_COUNT) begin
          tbl_handle[s] = 16'd0;
          words.push_back(make_word(ST_DELETED, 3'(s), 16'd0));
        end else begin
          words.push_back(make_word(ST_NOTFOUND, 3'd0, 16'd0));
        end
      end
      CMD_CHANGE: begin
        if (c.period != 16'd0) begin
          load_slot(int'(cur_slot), c);
          words.push_back(make_word(ST_CHANGED, 3'(cur_slot), 16'd0));
        end else begin
          words.push_back(make_word(ST_NOTFOUND, 3'd0, 16'd0));
        end
      end
      CMD_DISPATCH: begin
        for (s = 0; s < SLOT_COUNT; s++) begin
          if (words.size() < RESULT_LIMIT && tbl_handle[s] != 16'd0 &&
              tbl_count[s] == 17'd0) begin
            cur_slot = IDX_W'(s);
            tbl_count[s] = 17'(tbl_period[s]);
            words.push_back(make_word(ST_RUN, 3'(s), tbl_handle[s]));
          end
        end
        if (words.size() == 0) words.push_back(make_word(ST_IDLE, 3'd0, 16'd0));
      end
      default: return;
    endcase
    words[words.size() - 1].last = 1'b1;
    foreach (words[i]) due_words.push_back(words[i]);
  endfunction

  function automatic void queue_cmd(input logic [2:0] c, input logic [15:0] h,
                                    input logic [15:0] d, input logic [15:0] p);
    sched_cmd_t it;
    it.cmd = c;
    it.handle = h;
    it.first_delay = d;
    it.period = p;
    it.wait_drain = 1'b0;
    pending_cmds.push_back(it);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        tbl_handle[s] = 16'd0;
        tbl_count[s] = 17'd0;
        tbl_period[s] = 16'd0;
      end
      cur_slot = '0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        predict_results(on_wire);
        cmds_taken++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (pending_cmds.size() > 0 &&
            (calm || $urandom_range(0, 99) >= IDLE_PERCENT) &&
            !(pending_cmds[0].wait_drain && due_words.size() > 0)) begin
          on_wire = pending_cmds.pop_front();
          cmd <= on_wire.cmd;
          handle <= on_wire.handle;
          first_delay <= on_wire.first_delay;
          period <= on_wire.period;
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sched_word_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual status %0d slot %0d handle %0h",
                   $time, status, slot, task_handle);
          mismatches++;
        end else begin
          want = due_words.pop_front();
          check_field("status", 16'(want.status), 16'(status));
          check_field("slot", 16'(want.slot), 16'(slot));
          check_field("task_handle", want.task_handle, task_handle);
          check_field("last", 16'(want.last), 16'(last));
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && cmds_taken >= 60) begin
        hold_left = HOLDOFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL periodic_task_slot_scheduler");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    logic [2:0]  c;
    logic [15:0] h;
    logic [15:0] d;
    logic [15:0] p;

    // corner cases on an empty and then a full table
    queue_cmd(CMD_DISPATCH, 16'd0, 16'd0, 16'd0);
    queue_cmd(CMD_TICK, 16'd0, 16'd0, 16'd0);
    queue_cmd(CMD_DELETE, 16'd0, 16'd0, 16'd0);
    queue_cmd(CMD_DELETE, 16'h1234, 16'd0, 16'd0);
    queue_cmd(CMD_CHANGE, 16'h4321, 16'd5, 16'd0);
    queue_cmd(CMD_CHANGE, 16'hFFFF, 16'd0, 16'd1);
    queue_cmd(CMD_ADD, 16'h0042, 16'd3, 16'd0);
    queue_cmd(CMD_ADD, 16'd0, 16'd2, 16'd2);
    queue_cmd(CMD_ADD, 16'd1, 16'hFFFF, 16'hFFFF);
    queue_cmd(CMD_ADD, 16'h8000, 16'd0, 16'd1);
    queue_cmd(CMD_ADD, 16'h5555, 16'd0, 16'd1);
    queue_cmd(CMD_ADD, 16'hAAAA, 16'd0, 16'd1);
    queue_cmd(CMD_ADD, 16'd2, 16'd0, 16'd1);
    queue_cmd(CMD_ADD, 16'd3, 16'd0, 16'd1);
    queue_cmd(CMD_ADD, 16'd4, 16'd0, 16'd1);
    queue_cmd(CMD_ADD, 16'd5, 16'd0, 16'd1);
    queue_cmd(CMD_DELETE, 16'd1, 16'd0, 16'd0);
    queue_cmd(CMD_ADD, 16'h7FFF, 16'd0, 16'd1);
    queue_cmd(CMD_TICK, 16'd0, 16'd0, 16'd0);
    queue_cmd(CMD_DISPATCH, 16'd0, 16'd0, 16'd0);
    queue_cmd(CMD_CHANGE, 16'd9, 16'd2, 16'd3);
    queue_cmd(CMD_DISPATCH, 16'd0, 16'd0, 16'd0);
    queue_cmd(CMD_DISPATCH + 3'd1, 16'd7, 16'd7, 16'd7);
    queue_cmd(CMD_DISPATCH + 3'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(CMD_TICK, 16'd0, 16'd0, 16'd0);
    queue_cmd(CMD_DISPATCH, 16'd0, 16'd0, 16'd0);

    // random mix: handles from a small pool so deletes hit, short timers so
    // tasks fall due often
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) c = CMD_TICK;
      else if (r < 55) c = CMD_DISPATCH;
      else if (r < 72) c = CMD_ADD;
      else if (r < 88) c = CMD_DELETE;
      else if (r < 97) c = CMD_CHANGE;
      else c = CMD_DISPATCH + 3'($urandom_range(1, 3));
      h = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
      d = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      r = $urandom_range(0, 99);
      if (r < 5) p = 16'd0;
      else if (r < 10) p = 16'($urandom);
      else p = 16'($urandom_range(1, 4));
      queue_cmd(c, h, d, p);
    end
    pending_cmds[120].wait_drain = 1'b1;
    pending_cmds[300].wait_drain = 1'b1;
    total_cmds = pending_cmds.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (cmds_taken < total_cmds || due_words.size() != 0) @(posedge clk);
    repeat (4 * (SLOT_COUNT + 2)) @(posedge clk);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("PASS periodic_task_slot_scheduler");
    end else begin
      $display("FAIL periodic_task_slot_scheduler");
    end
    $finish;
  end

endmodule
